// File: rtl/rk4_scale_factor_step_macros.svh
// Assertion macros used by the checker file.
`ifndef RK4_SCALE_FACTOR_STEP_MACROS_SVH
`define RK4_SCALE_FACTOR_STEP_MACROS_SVH

// Same-cycle implication, clocked on clk_i and held off during reset.
`define RSF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsf assertion failed");

// Next-cycle implication, clocked on clk_i and held off during reset.
`define RSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsf assertion failed");

`endif

// File: rtl/rsf_pkg.sv
`timescale 1ns / 1ps

package rsf_pkg;

  // Input beat: restart flag and body count.
  typedef struct packed {
    logic        restart;
    logic [19:0] body_count;
  } in_t;

  // Output beat: new scale factor and overflow flag.
  typedef struct packed {
    logic [63:0] scale_out;
    logic        saturated;
  } out_t;

  // Result of the serial divider.
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] quot;
  } div_res_t;

  // Configuration register indexes.
  localparam logic [3:0] CFG_LAMBDA   = 4'd0;
  localparam logic [3:0] CFG_COUPLING = 4'd1;
  localparam logic [3:0] CFG_LIGHT    = 4'd2;
  localparam logic [3:0] CFG_WIDTH    = 4'd3;
  localparam logic [3:0] CFG_HEIGHT   = 4'd4;
  localparam logic [3:0] CFG_LSCALE   = 4'd5;
  localparam logic [3:0] CFG_TSTEP    = 4'd6;
  localparam logic [3:0] CFG_INIT     = 4'd7;

  // Divisors used by the step.
  localparam logic [63:0] DivThree = 64'd3;
  localparam logic [63:0] DivSix   = 64'd6;

  // Last iteration index of the serial units, which run one iteration per bit of a 64-bit word.
  localparam logic [5:0] LastIter = 6'd63;

  // Saturating 64-bit add; the top bit of the result flags overflow.
  function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_sat = s[64] ? {1'b1, {64{1'b1}}} : s;
  endfunction

endpackage

// File: rtl/rk4_scale_factor_step.sv
`timescale 1ns / 1ps

// One fourth-order Runge-Kutta step of a cosmological scale factor per stepping input beat.
// Input channel: in_valid_i / in_stall_o with in_data_i (restart, body_count).
// Output channel: out_valid_o / out_stall_i with out_data_o (scale_out, saturated).
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is high; write
// only while the block is idle. Indexes above the last register are ignored.
// A beat with restart set reloads the initial scale and returns it through the output register.
// A stepping beat runs 31 serial operations (multiply, divide or square root) in turn
// on the shared bit-serial units, each of which works one bit at a time.
// One beat is worked on at a time: in_stall_o is high from acceptance until the
// result is placed in the output register.
// A result that the receiver stalls waits in the output register; a next beat may be
// accepted meanwhile, and its result waits until the previous one is taken.
// Reset clears the configuration to its defaults and the scale factor to one.
module rk4_scale_factor_step #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rsf_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rsf_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_idx_i,
  input  logic [63:0]    cfg_data_i
);

  // 1e-10 rounded to nearest in the fixed-point format.
  localparam logic [63:0] EpsQ =
    ((64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam logic [63:0] QOne = 64'd1 << FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_C2   = 4'd1;
  localparam logic [3:0] ST_M    = 4'd2;
  localparam logic [3:0] ST_NUM  = 4'd3;
  localparam logic [3:0] ST_QD   = 4'd4;
  localparam logic [3:0] ST_S2   = 4'd5;
  localparam logic [3:0] ST_T2   = 4'd6;
  localparam logic [3:0] ST_P1   = 4'd7;
  localparam logic [3:0] ST_P2   = 4'd8;
  localparam logic [3:0] ST_T1   = 4'd9;
  localparam logic [3:0] ST_SQ   = 4'd10;
  localparam logic [3:0] ST_R    = 4'd11;
  localparam logic [3:0] ST_K    = 4'd12;
  localparam logic [3:0] ST_INC  = 4'd13;
  localparam logic [3:0] ST_OUT  = 4'd14;

  // Configuration registers.
  logic [63:0] lambda_q, coupling_q, light_q, lscale_q, tstep_q, init_q;
  logic [15:0] width_q, height_q;

  // Control state.
  logic [3:0]  state_q, state_d;
  logic        wait_q, wait_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] scale_q, scale_d;

  // Working registers.
  logic [63:0] a0_q, a0_d, acur_q, acur_d, c2_q, c2_d, tmp_q, tmp_d;
  logic [63:0] t2_q, t2_d, arg_q, arg_d, res_q, res_d;
  logic [66:0] acc_q, acc_d;
  logic [19:0] body_q, body_d;
  logic [33:0] den_q, den_d;
  logic [1:0]  stage_q, stage_d;
  logic        sat_q, sat_d;
  rsf_pkg::out_t out_data_q, out_data_d;

  // Unit interfaces.
  logic              mul_start, div_start, sq_start;
  logic [63:0]       mul_a, mul_b, div_hi, div_lo, div_den;
  logic              mul_done, sq_done, unit_done;
  logic [127:0]      mul_prod, mq_wide, div_wide;
  logic [63:0]       sq_root, mq, kval;
  logic              mq_ov, mi_ov;
  rsf_pkg::div_res_t div_res;
  logic              is_mul, is_div, is_sq;

  // Area denominator 3*w*h with zero dimensions taken as one.
  logic [15:0] wv, hv;
  logic [31:0] wh;
  logic [64:0] s1, s2, s3, s4;

  assign wv = (width_q == 16'd0) ? 16'd1 : width_q;
  assign hv = (height_q == 16'd0) ? 16'd1 : height_q;
  assign wh = wv * hv;

  // Fixed-point and integer views of the product; an overflow reads as all ones.
  assign mq_wide   = mul_prod >> FRAC_BITS;
  assign mq_ov     = |mq_wide[127:64];
  assign mq        = mq_ov ? {64{1'b1}} : mq_wide[63:0];
  assign mi_ov     = |mul_prod[127:64];
  assign kval      = mq;
  assign div_wide  = {64'd0, tmp_q} << FRAC_BITS;
  assign unit_done = mul_done | div_res.done | sq_done;

  rsf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  rsf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (div_hi),
    .num_lo_i (div_lo),
    .den_i    (div_den),
    .res_o    (div_res)
  );

  rsf_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (arg_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Operand selection for the unit that the current state uses.
  always_comb begin
    is_mul  = 1'b0;
    is_div  = 1'b0;
    is_sq   = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_hi  = '0;
    div_lo  = '0;
    div_den = '0;
    unique case (state_q)
      ST_C2: begin
        is_mul = 1'b1; mul_a = light_q; mul_b = light_q;
      end
      ST_M: begin
        is_mul = 1'b1; mul_a = coupling_q; mul_b = c2_q;
      end
      ST_NUM: begin
        is_mul = 1'b1; mul_a = tmp_q; mul_b = 64'(body_q);
      end
      ST_QD: begin
        is_div = 1'b1; div_lo = tmp_q; div_den = 64'(den_q);
      end
      ST_S2: begin
        is_mul = 1'b1; mul_a = lscale_q; mul_b = lscale_q;
      end
      ST_T2: begin
        is_div = 1'b1; div_hi = div_wide[127:64]; div_lo = div_wide[63:0];
        div_den = t2_q;
      end
      ST_P1: begin
        is_mul = 1'b1; mul_a = lambda_q; mul_b = acur_q;
      end
      ST_P2: begin
        is_mul = 1'b1; mul_a = tmp_q; mul_b = acur_q;
      end
      ST_T1: begin
        is_div = 1'b1; div_lo = tmp_q; div_den = rsf_pkg::DivThree;
      end
      ST_SQ: begin
        is_sq = 1'b1;
      end
      ST_R: begin
        is_mul = 1'b1; mul_a = light_q; mul_b = tmp_q;
      end
      ST_K: begin
        is_mul = 1'b1; mul_a = tmp_q; mul_b = tstep_q;
      end
      ST_INC: begin
        is_div = 1'b1; div_hi = {61'd0, acc_q[66:64]}; div_lo = acc_q[63:0];
        div_den = rsf_pkg::DivSix;
      end
      default: begin
      end
    endcase
  end

  assign mul_start = is_mul && !wait_q;
  assign div_start = is_div && !wait_q;
  assign sq_start  = is_sq && !wait_q;

  // Sequencer: launch an operation, wait for it, capture the result.
  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    scale_d     = scale_q;
    a0_d        = a0_q;
    acur_d      = acur_q;
    c2_d        = c2_q;
    tmp_d       = tmp_q;
    t2_d        = t2_q;
    arg_d       = arg_q;
    res_d       = res_q;
    acc_d       = acc_q;
    body_d      = body_q;
    den_d       = den_q;
    stage_d     = stage_q;
    sat_d       = sat_q;
    s1          = '0;
    s2          = '0;
    s3          = '0;
    s4          = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (state_q == ST_IDLE) begin
      if (in_valid_i) begin
        sat_d = 1'b0;
        if (in_data_i.restart) begin
          res_d   = init_q;
          state_d = ST_OUT;
        end else begin
          a0_d    = scale_q;
          acur_d  = scale_q;
          body_d  = in_data_i.body_count;
          den_d   = 34'({wh, 1'b0}) + 34'(wh);
          acc_d   = '0;
          stage_d = '0;
          state_d = ST_C2;
        end
      end
    end else if (state_q == ST_OUT) begin
      // Load the output register once the previous result has gone.
      if (!out_valid_q || !out_stall_i) begin
        out_valid_d = 1'b1;
        out_data_d  = '{scale_out: res_q, saturated: sat_q};
        scale_d     = res_q;
        state_d     = ST_IDLE;
      end
    end else if (!wait_q) begin
      wait_d = 1'b1;
    end else if (unit_done) begin
      wait_d = 1'b0;
      unique case (state_q)
        ST_C2: begin
          c2_d = mq; sat_d = sat_q | mq_ov; state_d = ST_M;
        end
        ST_M: begin
          tmp_d = mq; sat_d = sat_q | mq_ov; state_d = ST_NUM;
        end
        ST_NUM: begin
          tmp_d   = mi_ov ? {64{1'b1}} : mul_prod[63:0];
          sat_d   = sat_q | mi_ov;
          state_d = ST_QD;
        end
        ST_QD: begin
          tmp_d = div_res.quot; sat_d = sat_q | div_res.sat; state_d = ST_S2;
        end
        ST_S2: begin
          t2_d = mq; sat_d = sat_q | mq_ov; state_d = ST_T2;
        end
        ST_T2: begin
          t2_d = div_res.quot; sat_d = sat_q | div_res.sat; state_d = ST_P1;
        end
        ST_P1: begin
          tmp_d = mq; sat_d = sat_q | mq_ov; state_d = ST_P2;
        end
        ST_P2: begin
          tmp_d = mq; sat_d = sat_q | mq_ov; state_d = ST_T1;
        end
        ST_T1: begin
          // Root argument: lambda term, epsilon and matter term.
          s1      = rsf_pkg::add_sat(div_res.quot, EpsQ);
          s2      = rsf_pkg::add_sat(s1[63:0], t2_q);
          arg_d   = s2[63:0];
          sat_d   = sat_q | div_res.sat | s1[64] | s2[64];
          state_d = ST_SQ;
        end
        ST_SQ: begin
          tmp_d = sq_root; state_d = ST_R;
        end
        ST_R: begin
          tmp_d = mq; sat_d = sat_q | mq_ov; state_d = ST_K;
        end
        ST_K: begin
          // Weight the middle stages twice and form the next stage point.
          if (stage_q == 2'd1 || stage_q == 2'd2) begin
            acc_d = acc_q + {2'b00, kval, 1'b0};
          end else begin
            acc_d = acc_q + {3'b000, kval};
          end
          sat_d = sat_q | mq_ov;
          if (stage_q == 2'd3) begin
            state_d = ST_INC;
          end else begin
            s3      = rsf_pkg::add_sat(a0_q,
                        (stage_q == 2'd2) ? kval : {1'b0, kval[63:1]});
            acur_d  = s3[63:0];
            sat_d   = sat_q | mq_ov | s3[64];
            stage_d = stage_q + 2'd1;
            state_d = ST_P1;
          end
        end
        ST_INC: begin
          s4      = rsf_pkg::add_sat(a0_q, div_res.quot);
          res_d   = s4[63:0];
          sat_d   = sat_q | div_res.sat | s4[64];
          state_d = ST_OUT;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      scale_q     <= QOne;
      lambda_q    <= '0;
      coupling_q  <= '0;
      light_q     <= QOne;
      width_q     <= 16'd1;
      height_q    <= 16'd1;
      lscale_q    <= QOne;
      tstep_q     <= '0;
      init_q      <= QOne;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
      scale_q     <= scale_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rsf_pkg::CFG_LAMBDA:   lambda_q   <= cfg_data_i;
          rsf_pkg::CFG_COUPLING: coupling_q <= cfg_data_i;
          rsf_pkg::CFG_LIGHT:    light_q    <= cfg_data_i;
          rsf_pkg::CFG_WIDTH:    width_q    <= cfg_data_i[15:0];
          rsf_pkg::CFG_HEIGHT:   height_q   <= cfg_data_i[15:0];
          rsf_pkg::CFG_LSCALE:   lscale_q   <= cfg_data_i;
          rsf_pkg::CFG_TSTEP:    tstep_q    <= cfg_data_i;
          rsf_pkg::CFG_INIT:     init_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    a0_q       <= a0_d;
    acur_q     <= acur_d;
    c2_q       <= c2_d;
    tmp_q      <= tmp_d;
    t2_q       <= t2_d;
    arg_q      <= arg_d;
    res_q      <= res_d;
    acc_q      <= acc_d;
    body_q     <= body_d;
    den_q      <= den_d;
    stage_q    <= stage_d;
    sat_q      <= sat_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/rsf_mul.sv
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier: one multiplier bit per cycle, full 128-bit product.
module rsf_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);

  logic [63:0]  mcand_q, mplier_q;
  logic [127:0] prod_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [64:0]  sum;

  // Add the multiplicand into the upper half when the current bit is set.
  assign sum = {1'b0, prod_q[127:64]} + {1'b0, (mplier_q[0] ? mcand_q : 64'd0)};

  // Control: iteration count and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == rsf_pkg::LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: product shifts right as multiplier bits are consumed.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= a_i;
      mplier_q <= b_i;
      prod_q   <= '0;
    end else if (busy_q) begin
      prod_q   <= {sum, prod_q[63:1]};
      mplier_q <= {1'b0, mplier_q[63:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// File: rtl/rsf_div.sv
`timescale 1ns / 1ps

// Restoring divider of a 128-bit numerator by a 64-bit divisor, one quotient bit per
// cycle. A zero divisor or a quotient over 64 bits ends at once, saturated unless 0/0.
module rsf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_hi_i,
  input  logic [63:0]        num_lo_i,
  input  logic [63:0]        den_i,
  output rsf_pkg::div_res_t  res_o
);

  logic [63:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, sat_q;
  logic [64:0] shifted, diff;
  logic        take;

  // One restoring step: shift in the next numerator bit and try a subtract.
  assign shifted = {rem_q, quo_q[63]};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = (shifted >= {1'b0, den_q});

  // Control: early exit on the special cases, otherwise 64 steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (num_hi_i >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == rsf_pkg::LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the low numerator word shifts out while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_hi_i;
      if (den_i == 64'd0 && num_hi_i == 64'd0 && num_lo_i == 64'd0) begin
        quo_q <= '0;
        sat_q <= 1'b0;
      end else if (num_hi_i >= den_i) begin
        quo_q <= '1;
        sat_q <= 1'b1;
      end else begin
        quo_q <= num_lo_i;
        sat_q <= 1'b0;
      end
    end else if (busy_q) begin
      rem_q <= take ? diff[63:0] : shifted[63:0];
      quo_q <= {quo_q[62:0], take};
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quo_q;

endmodule

// File: rtl/rsf_sqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit square root of x * 2^FRAC_BITS, one root bit per cycle.
module rsf_sqrt #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [63:0] root_o
);

  logic [127:0] rad_q;
  logic [66:0]  rem_q, remsh, trial;
  logic [63:0]  root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q, take;

  // Bring down two radicand bits and test the next root bit.
  assign remsh = {rem_q[64:0], rad_q[127:126]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = (remsh >= trial);

  // Control: 64 steps and a done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == rsf_pkg::LastIter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: radicand shifts left two bits a step.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= 128'(x_i) << FRAC_BITS;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[125:0], 2'b00};
      rem_q  <= take ? (remsh - trial) : remsh;
      root_q <= {root_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/rsf_check.sv
`timescale 1ns / 1ps
`include "rk4_scale_factor_step_macros.svh"

// Port-level checks of the step block.
module rsf_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rsf_pkg::out_t out_data_o
);

  // An accepted beat makes the block busy on the next cycle.
  `RSF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled result stays valid and unchanged.
  `RSF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o))

  // A new result appears only out of a busy cycle.
  `RSF_ASSERT_IMPL(a_out_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind rk4_scale_factor_step rsf_check u_rsf_check (.*);

// File: bench/rk4_scale_factor_step_tb.sv
`timescale 1ns / 1ps

module rk4_scale_factor_step_tb;

  localparam logic [3:0] CFG_SPARE = 4'd12;
  localparam logic [3:0] CFG_TOP_SPARE = 4'hf;
  localparam logic [63:0] Q_ONE = 64'd1 << 32;
  localparam logic [63:0] EPS_Q = (Q_ONE + 64'd5000000000) / 64'd10000000000;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned LONG_HOLD = 6000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  rsf_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  rsf_pkg::out_t out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [3:0]    cfg_idx_i = '0;
  logic [63:0]   cfg_data_i = '0;

  // Mirror of the configuration and the integrated scale.
  logic [63:0] lambda_q, coupling_q, light_q, lscale_q, tstep_q, init_q, scale_q;
  logic [15:0] width_q, height_q;

  rsf_pkg::out_t scale_results[$];
  int unsigned   errors = 0;
  int unsigned   hold_left = 0;
  bit            idle_en = 1'b1;

  rk4_scale_factor_step dut (.*);

  // Clock and watchdog.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Fixed-point helpers; all but qsqrt flag overflow in sat.
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                       inout bit sat);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[95:32];
  endfunction

  function automatic logic [63:0] imul(input logic [63:0] a, input logic [63:0] n,
                                       inout bit sat);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, n};
    if (p[127:64] != 0) begin
      sat = 1'b1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b,
                                       inout bit sat);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) begin
      sat = 1'b1;
      return '1;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] wide_div(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [63:0] d, inout bit sat);
    logic [127:0] q;
    if (d == 0) begin
      if ((hi | lo) == 0) return '0;
      sat = 1'b1;
      return '1;
    end
    if (hi >= d) begin
      sat = 1'b1;
      return '1;
    end
    q = {hi, lo} / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] qsqrt(input logic [63:0] x);
    logic [127:0] n;
    logic [63:0]  r;
    logic [63:0]  c;
    n = {32'd0, x, 32'd0};
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // Friedmann growth rate at scale a for the given body count.
  function automatic logic [63:0] growth_rate(input logic [63:0] a, input logic [19:0] bodies,
                                              inout bit sat);
    logic [63:0] w, h, t1, c2, num, s2, t2, arg;
    w = (width_q == 0) ? 64'd1 : {48'd0, width_q};
    h = (height_q == 0) ? 64'd1 : {48'd0, height_q};
    t1 = qmul(qmul(lambda_q, a, sat), a, sat) / 64'd3;
    c2 = qmul(light_q, light_q, sat);
    num = imul(qmul(coupling_q, c2, sat), {44'd0, bodies}, sat);
    s2 = qmul(lscale_q, lscale_q, sat);
    num = num / (64'd3 * w * h);
    t2 = wide_div({32'd0, num[63:32]}, {num[31:0], 32'd0}, s2, sat);
    arg = sadd(sadd(t1, EPS_Q, sat), t2, sat);
    return qmul(light_q, qsqrt(arg), sat);
  endfunction

  // One RK4 step (or restart) of the mirrored scale; returns the expected beat.
  function automatic rsf_pkg::out_t advance_scale(input rsf_pkg::in_t b);
    rsf_pkg::out_t r;
    bit            sat;
    logic [63:0]   a0, k1, k2, k3, k4;
    logic [66:0]   total;
    sat = 1'b0;
    if (b.restart) begin
      scale_q = init_q;
      r.scale_out = scale_q;
      r.saturated = 1'b0;
      return r;
    end
    a0 = scale_q;
    k1 = qmul(growth_rate(a0, b.body_count, sat), tstep_q, sat);
    k2 = qmul(growth_rate(sadd(a0, k1 >> 1, sat), b.body_count, sat), tstep_q, sat);
    k3 = qmul(growth_rate(sadd(a0, k2 >> 1, sat), b.body_count, sat), tstep_q, sat);
    k4 = qmul(growth_rate(sadd(a0, k3, sat), b.body_count, sat), tstep_q, sat);
    total = {3'd0, k1} + 67'd2 * {3'd0, k2} + 67'd2 * {3'd0, k3} + {3'd0, k4};
    scale_q = sadd(a0, wide_div({61'd0, total[66:64]}, total[63:0], 64'd6, sat), sat);
    r.scale_out = scale_q;
    r.saturated = sat;
    return r;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    rsf_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scale_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        want = scale_results.pop_front();
        if (want.scale_out !== out_data_o.scale_out ||
            want.saturated !== out_data_o.saturated) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected scale %h sat %b, got scale %h sat %b",
                     want.scale_out, want.saturated, out_data_o.scale_out,
                     out_data_o.saturated);
        end
      end
    end
  end

  // Receiver stall pattern: random bursts while idling is on, plus one long hold-off.
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!idle_en) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall_i <= 1'b0;
      run_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 1) == 1) stall_left = $urandom_range(1, 14);
      run_left = $urandom_range(0, 40);
    end
  end

  // Offer one beat, with an optional random gap first, and predict it on acceptance.
  task automatic send_beat(input rsf_pkg::in_t b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    scale_results.push_back(advance_scale(b));
  endtask

  task automatic send_fields(input bit restart, input logic [19:0] bodies);
    rsf_pkg::in_t b;
    b.restart = restart;
    b.body_count = bodies;
    send_beat(b);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (scale_results.size() != 0) @(posedge clk_i);
  endtask

  // Register write; the caller lowers the write enable with cfg_close.
  task automatic cfg_write(input logic [3:0] idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      rsf_pkg::CFG_LAMBDA:   lambda_q = val;
      rsf_pkg::CFG_COUPLING: coupling_q = val;
      rsf_pkg::CFG_LIGHT:    light_q = val;
      rsf_pkg::CFG_WIDTH:    width_q = val[15:0];
      rsf_pkg::CFG_HEIGHT:   height_q = val[15:0];
      rsf_pkg::CFG_LSCALE:   lscale_q = val;
      rsf_pkg::CFG_TSTEP:    tstep_q = val;
      rsf_pkg::CFG_INIT:     init_q = val;
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_all(input logic [63:0] lam, input logic [63:0] cpl, input logic [63:0] lt,
                         input logic [15:0] w, input logic [15:0] h, input logic [63:0] ls,
                         input logic [63:0] ts, input logic [63:0] init);
    cfg_write(rsf_pkg::CFG_LAMBDA, lam);
    cfg_write(rsf_pkg::CFG_COUPLING, cpl);
    cfg_write(rsf_pkg::CFG_LIGHT, lt);
    cfg_write(rsf_pkg::CFG_WIDTH, {48'd0, w});
    cfg_write(rsf_pkg::CFG_HEIGHT, {48'd0, h});
    cfg_write(rsf_pkg::CFG_LSCALE, ls);
    cfg_write(rsf_pkg::CFG_TSTEP, ts);
    cfg_write(rsf_pkg::CFG_INIT, init);
    cfg_close();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A register value in Q32.32: mostly random below 2^max_shift LSBs, sometimes an extreme or fully random.
  function automatic logic [63:0] pick_q(input int unsigned max_shift);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return rand64();
      default: return rand64() >> (64 - $urandom_range(1, max_shift));
    endcase
  endfunction

  function automatic logic [19:0] pick_bodies();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 20'($urandom_range(0, 15));
      default: return 20'($urandom);
    endcase
  endfunction

  // Defaults after reset: a zero time step leaves the scale alone.
  task automatic test_reset_defaults();
    lambda_q = '0; coupling_q = '0; light_q = Q_ONE; width_q = 16'd1; height_q = 16'd1;
    lscale_q = Q_ONE; tstep_q = '0; init_q = Q_ONE; scale_q = Q_ONE;
    send_fields(1'b0, 20'd0);
    send_fields(1'b0, '1);
    send_fields(1'b1, 20'd5);
    drain();
  endtask

  // Field extremes, zero area, vanishing length scale, overflow and spare indexes.
  task automatic test_directed();
    cfg_all(Q_ONE >> 4, Q_ONE, Q_ONE, 16'd0, 16'd0, Q_ONE, Q_ONE >> 6, Q_ONE * 2);
    send_fields(1'b1, 20'd0);
    send_fields(1'b0, 20'd0);
    send_fields(1'b0, 20'd1);
    send_fields(1'b0, '1);
    drain();
    // Length scale squares to zero: empty matter term, then a saturating one.
    cfg_all(Q_ONE >> 4, Q_ONE, Q_ONE, 16'hffff, 16'hffff, 64'd1, Q_ONE >> 6, Q_ONE);
    send_fields(1'b1, 20'd0);
    send_fields(1'b0, 20'd0);
    send_fields(1'b0, 20'd7);
    drain();
    // Everything at full scale overflows.
    cfg_all('1, '1, '1, 16'hffff, 16'hffff, '1, '1, '1);
    send_fields(1'b0, '1);
    send_fields(1'b1, '1);
    send_fields(1'b0, 20'd0);
    drain();
    // Writes to spare indexes must leave every register alone.
    cfg_all('0, '0, '0, 16'd1, 16'd1, Q_ONE, Q_ONE, '0);
    cfg_write(CFG_SPARE, '1);
    cfg_write(CFG_TOP_SPARE, '1);
    cfg_close();
    send_fields(1'b1, 20'd3);
    send_fields(1'b0, 20'd3);
    send_fields(1'b0, '1);
    drain();
  endtask

  // Random configurations, each followed by a stretch of random ticks.
  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      cfg_all(pick_q(34), pick_q(36), pick_q(34), 16'($urandom), 16'($urandom),
              pick_q(36), pick_q(31), pick_q(35));
      for (int i = 0; i < per_phase; i++)
        send_fields($urandom_range(0, 6) == 0, pick_bodies());
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while beats keep coming.
  task automatic test_backpressure();
    hold_left = LONG_HOLD;
    for (int i = 0; i < 6; i++) send_fields($urandom_range(0, 3) == 0, pick_bodies());
    drain();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_quiet_tail();
    idle_en = 1'b0;
    for (int i = 0; i < 80; i++) send_fields($urandom_range(0, 6) == 0, pick_bodies());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_phases(8, 110);
    test_backpressure();
    test_random_phases(8, 110);
    test_quiet_tail();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rsf_pkg.sv
rtl/rsf_mul.sv
rtl/rsf_div.sv
rtl/rsf_sqrt.sv
rtl/rk4_scale_factor_step.sv
rtl/rsf_check.sv
bench/rk4_scale_factor_step_tb.sv
